// File: rtl/rdbs_pkg.sv
// ----------------------------------------------------------------------------
// rdbs_pkg
// Shared constants and types of the region discard bilinear sampler: memory
// geometry, register indexes and reset values, and the memory port records.
// ----------------------------------------------------------------------------
package rdbs_pkg;

   localparam int FEAT_DEPTH = 4096;
   localparam int FEAT_AW    = $clog2(FEAT_DEPTH);
   localparam int MAX_GRID   = 64;

   localparam int CSR_IW = 3;
   localparam int CSR_DW = 24;

   localparam logic [CSR_IW-1:0] CSR_MAP_HEIGHT    = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_MAP_WIDTH     = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_MAP_CHANNELS  = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_SPATIAL_SCALE = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_BIN_STEP_H    = 3'd4;
   localparam logic [CSR_IW-1:0] CSR_BIN_STEP_W    = 3'd5;

   localparam logic [6:0]  MAP_HEIGHT_RST    = 7'd64;
   localparam logic [6:0]  MAP_WIDTH_RST     = 7'd64;
   localparam logic [8:0]  MAP_CHANNELS_RST  = 9'd1;
   localparam logic [15:0] SPATIAL_SCALE_RST = 16'd4096;
   localparam logic [23:0] BIN_STEP_H_RST    = 24'd65536;
   localparam logic [23:0] BIN_STEP_W_RST    = 24'd65536;

   localparam logic ACT_WRITE  = 1'b0;
   localparam logic ACT_SAMPLE = 1'b1;

   typedef struct packed {
      logic               en;
      logic [FEAT_AW-1:0] addr;
      logic [15:0]        data;
   } feat_wr_type;

   typedef struct packed {
      logic               en;
      logic [FEAT_AW-1:0] addr_a;
      logic [FEAT_AW-1:0] addr_b;
      logic [FEAT_AW-1:0] addr_c;
      logic [FEAT_AW-1:0] addr_d;
   } feat_rd_type;

   typedef struct packed {
      logic signed [15:0] a;
      logic signed [15:0] b;
      logic signed [15:0] c;
      logic signed [15:0] d;
   } feat_quad_type;

endpackage

// File: rtl/rdbs_channels.sv
// ----------------------------------------------------------------------------
// rdbs_channels
// Valid/ready channels of the sampler: request, response and register write.
// ----------------------------------------------------------------------------
interface rdbs_req_if;
   logic               valid;
   logic               ready;
   logic               action;
   logic [11:0]        feat_addr;
   logic signed [15:0] feat_value;
   logic [1:0]         batch_index;
   logic [7:0]         channel_index;
   logic [5:0]         out_row;
   logic [5:0]         out_col;
   logic [15:0]        roi_x0;
   logic [15:0]        roi_y0;
   logic [15:0]        roi_x1;
   logic [15:0]        roi_y1;

   modport source (output valid, action, feat_addr, feat_value, batch_index, channel_index,
                   out_row, out_col, roi_x0, roi_y0, roi_x1, roi_y1, input ready);
   modport sink (input valid, action, feat_addr, feat_value, batch_index, channel_index,
                 out_row, out_col, roi_x0, roi_y0, roi_x1, roi_y1, output ready);
endinterface

interface rdbs_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] sample_value;
   logic               discarded;
   logic               addr_error;

   modport source (output valid, sample_value, discarded, addr_error, input ready);
   modport sink (input valid, sample_value, discarded, addr_error, output ready);
endinterface

interface rdbs_csr_if;
   import rdbs_pkg::*;
   logic              valid;
   logic              ready;
   logic [CSR_IW-1:0] index;
   logic [CSR_DW-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/rdbs_feat_mem.sv
// ----------------------------------------------------------------------------
// rdbs_feat_mem
// Feature memory held as two identical copies with two read ports each, so
// that all four neighbor words of a sample are read in the same cycle.
// ----------------------------------------------------------------------------
module rdbs_feat_mem (
   input  logic                    clock,
   input  rdbs_pkg::feat_wr_type   wr_req,
   input  rdbs_pkg::feat_rd_type   rd_req,
   output rdbs_pkg::feat_quad_type rd_data
);
   import rdbs_pkg::*;

   logic [15:0]   upper_mem_ff [FEAT_DEPTH];
   logic [15:0]   lower_mem_ff [FEAT_DEPTH];
   feat_quad_type quad_ff;

   always_ff @(posedge clock) begin
      if (wr_req.en) begin
         upper_mem_ff[wr_req.addr] <= wr_req.data;
         lower_mem_ff[wr_req.addr] <= wr_req.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_req.en) begin
         quad_ff.a <= upper_mem_ff[rd_req.addr_a];
         quad_ff.b <= upper_mem_ff[rd_req.addr_b];
         quad_ff.c <= lower_mem_ff[rd_req.addr_c];
         quad_ff.d <= lower_mem_ff[rd_req.addr_d];
      end
   end

   assign rd_data = quad_ff;

endmodule

// File: rtl/region_discard_bilinear_sampler.sv
// A request transfer loads the first of nine pipeline registers; the last one drives
// the response. Throughput: one request per cycle while the response is not stalled,
// writes and samples in any order; two dual-read copies of the feature memory deliver
// all four neighbor words in the same cycle.
// Results leave in request order; a stalled response backs up only full stages.
// Synchronous reset clears the valid bits and loads register defaults, not memory.
// ----------------------------------------------------------------------------
// region_discard_bilinear_sampler
// Pipelined bilinear sampler over a feature memory, with a zero result for
// grid points inside a scaled region box and an address range flag.
// ----------------------------------------------------------------------------
module region_discard_bilinear_sampler (
   input logic        clock,
   input logic        reset,
   rdbs_req_if.sink   req_chan,
   rdbs_rsp_if.source rsp_chan,
   rdbs_csr_if.sink   csr_chan
);
   import rdbs_pkg::*;

   typedef struct packed {
      logic        is_write;
      logic [11:0] wr_addr;
      logic [15:0] wr_value;
      logic [29:0] h16;
      logic [29:0] w16;
      logic [31:0] bx0;
      logic [31:0] by0;
      logic [31:0] bx1;
      logic [31:0] by1;
      logic [10:0] bc;
   } s1_type;

   typedef struct packed {
      logic        is_write;
      logic [11:0] wr_addr;
      logic [15:0] wr_value;
      logic        discard;
      logic [6:0]  hs;
      logic [6:0]  ws;
      logic [29:0] hr;
      logic [29:0] wf;
      logic [10:0] bc;
   } s2_type;

   typedef struct packed {
      logic        is_write;
      logic [11:0] wr_addr;
      logic [15:0] wr_value;
      logic        discard;
      logic [6:0]  ws;
      logic [29:0] hr;
      logic [29:0] wf;
      logic [17:0] t;
   } s3_type;

   typedef struct packed {
      logic        is_write;
      logic [11:0] wr_addr;
      logic [15:0] wr_value;
      logic        discard;
      logic [29:0] hr;
      logic [29:0] wf;
      logic [24:0] base;
   } s4_type;

   typedef struct packed {
      logic        zero;
      logic        discard;
      logic        err;
      logic [29:0] hr;
      logic [29:0] wf;
   } s5_type;

   typedef struct packed {
      logic               zero;
      logic               discard;
      logic               err;
      logic [29:0]        hr;
      logic signed [15:0] a;
      logic signed [15:0] c;
      logic signed [47:0] p_top;
      logic signed [47:0] p_bot;
   } s6_type;

   typedef struct packed {
      logic               zero;
      logic               discard;
      logic               err;
      logic [29:0]        hr;
      logic signed [31:0] top;
      logic signed [32:0] diff;
   } s7_type;

   typedef struct packed {
      logic               zero;
      logic               discard;
      logic               err;
      logic signed [31:0] top;
      logic signed [63:0] prod;
   } s8_type;

   typedef struct packed {
      logic signed [15:0] sample_value;
      logic               discarded;
      logic               addr_error;
   } out_type;

   logic [6:0]  map_height_ff;
   logic [6:0]  map_width_ff;
   logic [8:0]  map_channels_ff;
   logic [15:0] spatial_scale_ff;
   logic [23:0] bin_step_h_ff;
   logic [23:0] bin_step_w_ff;

   logic [8:1]  valid_ff;
   logic        out_valid_ff;
   logic [9:1]  stage_load;

   s1_type  s1_ff, s1_in;
   s2_type  s2_ff, s2_in;
   s3_type  s3_ff, s3_in;
   s4_type  s4_ff, s4_in;
   s5_type  s5_ff, s5_in;
   s6_type  s6_ff, s6_in;
   s7_type  s7_ff, s7_in;
   s8_type  s8_ff, s8_in;
   out_type out_ff, out_in;

   logic [6:0]  hm;
   logic [6:0]  wm;
   logic [5:0]  row_c;
   logic [5:0]  col_c;
   logic [33:0] pos_h;
   logic [33:0] pos_w;
   logic [13:0] hs_raw;
   logic [13:0] ws_raw;
   logic [6:0]  lim_h;
   logic [6:0]  lim_w;
   logic [25:0] end_addr;
   logic        base_oob;
   logic        wr_oob;

   logic signed [16:0] d_top;
   logic signed [16:0] d_bot;
   logic signed [30:0] wf_s;
   logic signed [47:0] sum_top;
   logic signed [47:0] sum_bot;
   logic signed [31:0] top_v;
   logic signed [31:0] bot_v;
   logic signed [63:0] fin;
   logic signed [47:0] res;
   logic signed [15:0] sat_v;

   feat_wr_type   wr_req;
   feat_rd_type   rd_req;
   feat_quad_type rd_q;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_height_ff    <= MAP_HEIGHT_RST;
         map_width_ff     <= MAP_WIDTH_RST;
         map_channels_ff  <= MAP_CHANNELS_RST;
         spatial_scale_ff <= SPATIAL_SCALE_RST;
         bin_step_h_ff    <= BIN_STEP_H_RST;
         bin_step_w_ff    <= BIN_STEP_W_RST;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_MAP_HEIGHT:    map_height_ff    <= csr_chan.data[6:0];
            CSR_MAP_WIDTH:     map_width_ff     <= csr_chan.data[6:0];
            CSR_MAP_CHANNELS:  map_channels_ff  <= csr_chan.data[8:0];
            CSR_SPATIAL_SCALE: spatial_scale_ff <= csr_chan.data[15:0];
            CSR_BIN_STEP_H:    bin_step_h_ff    <= csr_chan.data[23:0];
            CSR_BIN_STEP_W:    bin_step_w_ff    <= csr_chan.data[23:0];
            default: begin
            end
         endcase
      end
   end

   assign csr_chan.ready = 1'b1;

   assign hm = (map_height_ff < 7'd2) ? 7'd2 : map_height_ff;
   assign wm = (map_width_ff < 7'd2) ? 7'd2 : map_width_ff;

   always_comb begin
      stage_load[9] = !out_valid_ff || rsp_chan.ready;
      for (int k = 8; k >= 1; k--) begin
         stage_load[k] = !valid_ff[k] || stage_load[k+1];
      end
   end

   assign req_chan.ready = stage_load[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (stage_load[1]) begin
            valid_ff[1] <= req_chan.valid;
         end
         for (int k = 2; k <= 8; k++) begin
            if (stage_load[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
         if (stage_load[9]) begin
            out_valid_ff <= valid_ff[8];
         end
      end
   end

   // Grid point and scaled box edges.
   always_comb begin
      row_c = req_chan.out_row;
      col_c = req_chan.out_col;
      if ({3'b000, req_chan.out_row} > 9'(MAX_GRID - 1)) begin
         row_c = 6'(MAX_GRID - 1);
      end
      if ({3'b000, req_chan.out_col} > 9'(MAX_GRID - 1)) begin
         col_c = 6'(MAX_GRID - 1);
      end
      s1_in.is_write = (req_chan.action == ACT_WRITE);
      s1_in.wr_addr  = req_chan.feat_addr;
      s1_in.wr_value = req_chan.feat_value;
      s1_in.h16      = 30'(row_c) * 30'(bin_step_h_ff);
      s1_in.w16      = 30'(col_c) * 30'(bin_step_w_ff);
      s1_in.bx0      = 32'(req_chan.roi_x0) * 32'(spatial_scale_ff);
      s1_in.by0      = 32'(req_chan.roi_y0) * 32'(spatial_scale_ff);
      s1_in.bx1      = 32'(req_chan.roi_x1) * 32'(spatial_scale_ff);
      s1_in.by1      = 32'(req_chan.roi_y1) * 32'(spatial_scale_ff);
      s1_in.bc       = 11'(req_chan.batch_index) * 11'(map_channels_ff)
                       + 11'(req_chan.channel_index);
   end

   // Box test, clamped corner and fractions.
   always_comb begin
      pos_h  = {s1_ff.h16, 4'b0000};
      pos_w  = {s1_ff.w16, 4'b0000};
      hs_raw = s1_ff.h16[29:16];
      ws_raw = s1_ff.w16[29:16];
      lim_h  = hm - 7'd2;
      lim_w  = wm - 7'd2;
      s2_in.is_write = s1_ff.is_write;
      s2_in.wr_addr  = s1_ff.wr_addr;
      s2_in.wr_value = s1_ff.wr_value;
      s2_in.discard  = (pos_h >= {2'b00, s1_ff.by0}) && (pos_h <= {2'b00, s1_ff.by1}) &&
                       (pos_w >= {2'b00, s1_ff.bx0}) && (pos_w <= {2'b00, s1_ff.bx1});
      s2_in.hs = (hs_raw > {7'b0000000, lim_h}) ? lim_h : hs_raw[6:0];
      s2_in.ws = (ws_raw > {7'b0000000, lim_w}) ? lim_w : ws_raw[6:0];
      s2_in.hr = s1_ff.h16 - {7'b0000000, s2_in.hs, 16'h0000};
      s2_in.wf = s1_ff.w16 - {7'b0000000, s2_in.ws, 16'h0000};
      s2_in.bc = s1_ff.bc;
   end

   always_comb begin
      s3_in.is_write = s2_ff.is_write;
      s3_in.wr_addr  = s2_ff.wr_addr;
      s3_in.wr_value = s2_ff.wr_value;
      s3_in.discard  = s2_ff.discard;
      s3_in.ws       = s2_ff.ws;
      s3_in.hr       = s2_ff.hr;
      s3_in.wf       = s2_ff.wf;
      s3_in.t        = 18'(s2_ff.bc) * 18'(hm) + 18'(s2_ff.hs);
   end

   always_comb begin
      s4_in.is_write = s3_ff.is_write;
      s4_in.wr_addr  = s3_ff.wr_addr;
      s4_in.wr_value = s3_ff.wr_value;
      s4_in.discard  = s3_ff.discard;
      s4_in.hr       = s3_ff.hr;
      s4_in.wf       = s3_ff.wf;
      s4_in.base     = 25'(s3_ff.t) * 25'(wm) + 25'(s3_ff.ws);
   end

   // Memory access stage. Writes and reads happen at the same stage, so a
   // sample always sees every write that was transferred before it.
   always_comb begin
      end_addr = 26'(s4_ff.base) + 26'(wm) + 26'd1;
      base_oob = (end_addr >= 26'(FEAT_DEPTH));
      wr_oob   = (17'(s4_ff.wr_addr) >= 17'(FEAT_DEPTH));

      wr_req.en   = valid_ff[4] && s4_ff.is_write && !wr_oob && stage_load[5];
      wr_req.addr = FEAT_AW'(s4_ff.wr_addr);
      wr_req.data = s4_ff.wr_value;

      rd_req.en     = stage_load[5];
      rd_req.addr_a = FEAT_AW'(s4_ff.base);
      rd_req.addr_b = FEAT_AW'(s4_ff.base + 25'd1);
      rd_req.addr_c = FEAT_AW'(s4_ff.base + 25'(wm));
      rd_req.addr_d = FEAT_AW'(end_addr);

      s5_in.zero    = s4_ff.is_write || s4_ff.discard || base_oob;
      s5_in.discard = !s4_ff.is_write && s4_ff.discard;
      s5_in.err     = s4_ff.is_write ? wr_oob : (!s4_ff.discard && base_oob);
      s5_in.hr      = s4_ff.hr;
      s5_in.wf      = s4_ff.wf;
   end

   rdbs_feat_mem u_feat_mem (
      .clock   (clock),
      .wr_req  (wr_req),
      .rd_req  (rd_req),
      .rd_data (rd_q)
   );

   always_comb begin
      d_top = {rd_q.b[15], rd_q.b} - {rd_q.a[15], rd_q.a};
      d_bot = {rd_q.d[15], rd_q.d} - {rd_q.c[15], rd_q.c};
      wf_s  = $signed({1'b0, s5_ff.wf});
      s6_in.zero    = s5_ff.zero;
      s6_in.discard = s5_ff.discard;
      s6_in.err     = s5_ff.err;
      s6_in.hr      = s5_ff.hr;
      s6_in.a       = rd_q.a;
      s6_in.c       = rd_q.c;
      s6_in.p_top   = d_top * wf_s;
      s6_in.p_bot   = d_bot * wf_s;
   end

   always_comb begin
      sum_top = {{16{s6_ff.a[15]}}, s6_ff.a, 16'h8000} + s6_ff.p_top;
      sum_bot = {{16{s6_ff.c[15]}}, s6_ff.c, 16'h8000} + s6_ff.p_bot;
      top_v   = sum_top[47:16];
      bot_v   = sum_bot[47:16];
      s7_in.zero    = s6_ff.zero;
      s7_in.discard = s6_ff.discard;
      s7_in.err     = s6_ff.err;
      s7_in.hr      = s6_ff.hr;
      s7_in.top     = top_v;
      s7_in.diff    = {bot_v[31], bot_v} - {top_v[31], top_v};
   end

   // The row mix stays well below 2^62 in magnitude, so plain saturation of
   // the rounded sum covers every extrapolation.
   always_comb begin
      s8_in.zero    = s7_ff.zero;
      s8_in.discard = s7_ff.discard;
      s8_in.err     = s7_ff.err;
      s8_in.top     = s7_ff.top;
      s8_in.prod    = s7_ff.diff * $signed({1'b0, s7_ff.hr});
   end

   always_comb begin
      fin = {{16{s8_ff.top[31]}}, s8_ff.top, 16'h8000} + s8_ff.prod;
      res = fin[63:16];
      if (res > 48'sd32767) begin
         sat_v = 16'sh7FFF;
      end else if (res < -48'sd32768) begin
         sat_v = 16'sh8000;
      end else begin
         sat_v = res[15:0];
      end
      out_in.sample_value = s8_ff.zero ? 16'sd0 : sat_v;
      out_in.discarded    = s8_ff.discard;
      out_in.addr_error   = s8_ff.err;
   end

   always_ff @(posedge clock) begin
      if (stage_load[1]) s1_ff <= s1_in;
      if (stage_load[2]) s2_ff <= s2_in;
      if (stage_load[3]) s3_ff <= s3_in;
      if (stage_load[4]) s4_ff <= s4_in;
      if (stage_load[5]) s5_ff <= s5_in;
      if (stage_load[6]) s6_ff <= s6_in;
      if (stage_load[7]) s7_ff <= s7_in;
      if (stage_load[8]) s8_ff <= s8_in;
      if (stage_load[9]) out_ff <= out_in;
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.sample_value = out_ff.sample_value;
   assign rsp_chan.discarded    = out_ff.discarded;
   assign rsp_chan.addr_error   = out_ff.addr_error;

`ifndef ASSERT_OFF
   a_req_enters: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> valid_ff[1])
      else $error("A request transfer did not enter the first stage.");

   a_last_stage_moves: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[8] && stage_load[9]) |=> out_valid_ff)
      else $error("A finished item did not reach the response register.");

   a_write_result: assert property (@(posedge clock) disable iff (reset)
      wr_req.en |=> (valid_ff[5] && s5_ff.zero && !s5_ff.err))
      else $error("A memory write did not yield a clean zero result.");

   a_zero_value: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_ff.discarded || out_ff.addr_error))
      |-> (out_ff.sample_value == 16'sd0))
      else $error("A discarded or failed sample carries a value.");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.discarded) |-> !out_ff.addr_error)
      else $error("A discarded sample also flags an address error.");
`endif

endmodule
